FILE: hdl/rrts_pkg.sv
`default_nettype none

package rrts_pkg;

  // Table size and the widths that follow from it
  localparam int MAX_TASKS = 32;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Fixed field widths
  localparam int FUNC_W     = 2;
  localparam int TID_W      = 5;
  localparam int PRIO_W     = 8;
  localparam int UNIT_W     = 10;
  localparam int SLICE_W    = 18;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // Reset values
  localparam logic [UNIT_W-1:0] RESET_SLICE_UNIT = UNIT_W'(100);
  localparam logic [PRIO_W-1:0] RESET_PRIORITY   = PRIO_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_RUN    = 2'd1,
    FUNC_SWITCH = 2'd2,
    FUNC_SLEEP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_CREATED = 2'd1,
    SLOT_RUNNING = 2'd2
  } slot_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_SLOT   = 2'd1,
    STATUS_SOLE_TASK = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLICE_UNIT       = 1'd0,
    CFG_DEFAULT_PRIORITY = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ALLOC,
    ST_SLEEP,
    ST_HEAD,
    ST_MUL
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic alloc_step;
    logic sleep_step;
    logic head;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    func_t func;
    logic  sleep_go;
    logic  alloc_done;
    logic  sleep_last;
    logic  out_free;
  } sts_t;

  // Slot number from the task_id field into a table index
  function automatic logic [IDX_W-1:0] tid_to_idx(input logic [TID_W-1:0] tid);
    logic [IDX_W+TID_W-1:0] wide;
    wide = (IDX_W + TID_W)'(tid);
    return wide[IDX_W-1:0];
  endfunction

  // Task_id names a slot inside the table
  function automatic logic tid_in_range(input logic [TID_W-1:0] tid);
    logic [IDX_W+TID_W:0] wide;
    wide = (IDX_W + TID_W + 1)'(tid);
    return wide < (IDX_W + TID_W + 1)'(MAX_TASKS);
  endfunction

  // Table index into a reported slot number, masked to the field width
  function automatic logic [TID_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+TID_W-1:0] wide;
    wide = (IDX_W + TID_W)'(idx);
    return wide[TID_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rrts_ctrl.sv
`default_nettype none

module rrts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rrts_pkg::sts_t sts,
  output rrts_pkg::cmd_t     cmd
);

  rrts_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      rrts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = rrts_pkg::ST_EXEC;
        end
      end
      rrts_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        priority if (sts.func == rrts_pkg::FUNC_ALLOC) begin
          state_nxt = rrts_pkg::ST_ALLOC;
        end else if (sts.func == rrts_pkg::FUNC_SLEEP && sts.sleep_go) begin
          state_nxt = rrts_pkg::ST_SLEEP;
        end else begin
          state_nxt = rrts_pkg::ST_HEAD;
        end
      end
      rrts_pkg::ST_ALLOC: begin
        cmd.alloc_step = 1'b1;
        if (sts.alloc_done) begin
          state_nxt = rrts_pkg::ST_HEAD;
        end
      end
      rrts_pkg::ST_SLEEP: begin
        cmd.sleep_step = 1'b1;
        if (sts.sleep_last) begin
          state_nxt = rrts_pkg::ST_HEAD;
        end
      end
      rrts_pkg::ST_HEAD: begin
        cmd.head  = 1'b1;
        state_nxt = rrts_pkg::ST_MUL;
      end
      rrts_pkg::ST_MUL: begin
        // Hold until the output register can take the result
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = rrts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rrts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/rrts_dp.sv
`default_nettype none

module rrts_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [rrts_pkg::FUNC_W-1:0]       in_func,
  input  wire logic [rrts_pkg::TID_W-1:0]        in_task_id,
  input  wire logic [rrts_pkg::PRIO_W-1:0]       in_priority_req,
  input  wire logic                              cfg_we,
  input  wire logic [rrts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rrts_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire rrts_pkg::cmd_t                    cmd,
  output rrts_pkg::sts_t                         sts,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [rrts_pkg::TID_W-1:0]             out_given_task,
  output logic [rrts_pkg::TID_W-1:0]             out_current_task,
  output logic [rrts_pkg::SLICE_W-1:0]           out_slice_length,
  output logic                                   out_start_switch,
  output logic [rrts_pkg::STATUS_W-1:0]          out_status
);

  localparam int N     = rrts_pkg::MAX_TASKS;
  localparam int IDX_W = rrts_pkg::IDX_W;
  localparam int CNT_W = rrts_pkg::CNT_W;

  // Task tables
  rrts_pkg::slot_t             state_r [N];
  logic [rrts_pkg::PRIO_W-1:0] prio_r  [N];
  logic [IDX_W-1:0]            rl_r    [N];

  // Scheduler state and configuration
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [IDX_W-1:0]             pos_r, pos_nxt;
  logic [rrts_pkg::UNIT_W-1:0]  unit_r, unit_nxt;
  logic [rrts_pkg::PRIO_W-1:0]  defp_r, defp_nxt;

  // Operation in progress
  rrts_pkg::func_t              func_r, func_nxt;
  logic [rrts_pkg::TID_W-1:0]   tid_r, tid_nxt;
  logic [rrts_pkg::PRIO_W-1:0]  preq_r, preq_nxt;
  logic [CNT_W-1:0]             j_r, j_nxt;
  logic                         found_r, found_nxt;
  logic [IDX_W-1:0]             k_r, k_nxt;
  logic [IDX_W-1:0]             cur_r, cur_nxt;
  logic [IDX_W-1:0]             given_r, given_nxt;
  logic                         gave_r, gave_nxt;
  rrts_pkg::status_t            status_r, status_nxt;
  logic                         sw_r, sw_nxt;

  // Output register
  logic                         ov_r, ov_nxt;
  logic [rrts_pkg::TID_W-1:0]   og_r, og_nxt;
  logic [rrts_pkg::TID_W-1:0]   oc_r, oc_nxt;
  logic [rrts_pkg::SLICE_W-1:0] os_r, os_nxt;
  logic                         osw_r, osw_nxt;
  rrts_pkg::status_t            ost_r, ost_nxt;

  // Table write ports
  logic                         st_we, prio_we, rl_we;
  logic [IDX_W-1:0]             st_wa, prio_wa, rl_wa;
  rrts_pkg::slot_t              st_wd;
  logic [rrts_pkg::PRIO_W-1:0]  prio_wd;
  logic [IDX_W-1:0]             rl_wd;

  // Table reads and derived values
  logic [IDX_W-1:0]             tid_idx;
  logic                         tid_ok;
  logic [IDX_W-1:0]             j_idx;
  logic [IDX_W-1:0]             st_ra, rl_ra;
  rrts_pkg::slot_t              st_rd;
  logic [IDX_W-1:0]             rl_rd;
  logic [rrts_pkg::PRIO_W-1:0]  prio_rd;
  logic [CNT_W-1:0]             count_dec;
  logic [CNT_W-1:0]             pos_inc;
  logic [IDX_W-1:0]             k_eff;
  logic                         match;
  logic                         alloc_last;

  assign tid_idx   = rrts_pkg::tid_to_idx(tid_r);
  assign tid_ok    = rrts_pkg::tid_in_range(tid_r);
  assign j_idx     = j_r[IDX_W-1:0];
  // Alloc scans by the step counter; every other operation looks at its own slot
  assign st_ra     = (func_r == rrts_pkg::FUNC_ALLOC) ? j_idx : tid_idx;
  assign rl_ra     = cmd.head ? pos_r : j_idx;
  assign st_rd     = state_r[st_ra];
  assign rl_rd     = rl_r[rl_ra];
  assign prio_rd   = prio_r[cur_r];
  assign count_dec = count_r - CNT_W'(1);
  assign pos_inc   = CNT_W'(pos_r) + CNT_W'(1);
  assign k_eff     = found_r ? k_r : j_idx;
  assign match     = (rl_rd == tid_idx);
  assign alloc_last = (j_idx == IDX_W'(N - 1));

  // Status to the controller
  assign sts.func       = func_r;
  assign sts.sleep_go   = tid_ok && (st_rd == rrts_pkg::SLOT_RUNNING)
                          && (count_r >= CNT_W'(2));
  assign sts.alloc_done = (st_rd == rrts_pkg::SLOT_EMPTY) || alloc_last;
  assign sts.sleep_last = (j_r == count_dec);
  assign sts.out_free   = !ov_r || out_ready;

  // Operation sequencing
  always_comb begin
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    unit_nxt   = unit_r;
    defp_nxt   = defp_r;
    func_nxt   = func_r;
    tid_nxt    = tid_r;
    preq_nxt   = preq_r;
    j_nxt      = j_r;
    found_nxt  = found_r;
    k_nxt      = k_r;
    cur_nxt    = cur_r;
    given_nxt  = given_r;
    gave_nxt   = gave_r;
    status_nxt = status_r;
    sw_nxt     = sw_r;
    st_we      = 1'b0;
    st_wa      = tid_idx;
    st_wd      = rrts_pkg::SLOT_CREATED;
    prio_we    = 1'b0;
    prio_wa    = tid_idx;
    prio_wd    = preq_r;
    rl_we      = 1'b0;
    rl_wa      = j_idx;
    rl_wd      = rl_rd;

    // Configuration writes
    if (cfg_we) begin
      unique case (rrts_pkg::cfg_reg_t'(cfg_index))
        rrts_pkg::CFG_SLICE_UNIT:       unit_nxt = cfg_wdata[rrts_pkg::UNIT_W-1:0];
        rrts_pkg::CFG_DEFAULT_PRIORITY: defp_nxt = cfg_wdata[rrts_pkg::PRIO_W-1:0];
        default: ;
      endcase
    end

    // Capture a new item
    if (cmd.accept) begin
      func_nxt   = rrts_pkg::func_t'(in_func);
      tid_nxt    = in_task_id;
      preq_nxt   = in_priority_req;
      j_nxt      = '0;
      found_nxt  = 1'b0;
      gave_nxt   = 1'b0;
      status_nxt = rrts_pkg::STATUS_OK;
      sw_nxt     = 1'b0;
    end

    // Run and switch operations and the sleep precheck
    if (cmd.exec) begin
      unique case (func_r)
        rrts_pkg::FUNC_RUN: begin
          if (tid_ok) begin
            prio_we = (preq_r != '0);
            if (st_rd != rrts_pkg::SLOT_RUNNING && count_r < CNT_W'(N)) begin
              st_we     = 1'b1;
              st_wd     = rrts_pkg::SLOT_RUNNING;
              rl_we     = 1'b1;
              rl_wa     = count_r[IDX_W-1:0];
              rl_wd     = tid_idx;
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end
        rrts_pkg::FUNC_SWITCH: begin
          pos_nxt = (pos_inc >= count_r) ? '0 : pos_inc[IDX_W-1:0];
          sw_nxt  = (count_r >= CNT_W'(2));
        end
        rrts_pkg::FUNC_SLEEP: begin
          if (tid_ok && st_rd == rrts_pkg::SLOT_RUNNING && count_r < CNT_W'(2)) begin
            status_nxt = rrts_pkg::STATUS_SOLE_TASK;
          end
        end
        default: ;
      endcase
    end

    // Scan for the lowest empty slot
    if (cmd.alloc_step) begin
      j_nxt = j_r + CNT_W'(1);
      if (st_rd == rrts_pkg::SLOT_EMPTY) begin
        st_we     = 1'b1;
        st_wa     = j_idx;
        st_wd     = rrts_pkg::SLOT_CREATED;
        prio_we   = 1'b1;
        prio_wa   = j_idx;
        prio_wd   = defp_r;
        given_nxt = j_idx;
        gave_nxt  = 1'b1;
      end else if (alloc_last) begin
        status_nxt = rrts_pkg::STATUS_NO_SLOT;
      end
    end

    // Find the task in the run list and close the gap behind it
    if (cmd.sleep_step) begin
      j_nxt = j_r + CNT_W'(1);
      if (!found_r && match) begin
        found_nxt = 1'b1;
        k_nxt     = j_idx;
      end else if (found_r) begin
        rl_we = 1'b1;
        rl_wa = j_idx - IDX_W'(1);
        rl_wd = rl_rd;
      end
      if (sts.sleep_last) begin
        count_nxt = count_dec;
        st_we     = 1'b1;
        st_wa     = tid_idx;
        st_wd     = rrts_pkg::SLOT_CREATED;
        if (k_eff < pos_r) begin
          pos_nxt = pos_r - IDX_W'(1);
        end else if (k_eff == pos_r) begin
          sw_nxt = 1'b1;
          if (CNT_W'(pos_r) >= count_dec) begin
            pos_nxt = '0;
          end
        end
      end
    end

    // Fetch the current task
    if (cmd.head) begin
      cur_nxt = rl_rd;
    end
  end

  // Output register
  always_comb begin
    ov_nxt  = ov_r;
    og_nxt  = og_r;
    oc_nxt  = oc_r;
    os_nxt  = os_r;
    osw_nxt = osw_r;
    ost_nxt = ost_r;
    if (cmd.out_load) begin
      ov_nxt  = 1'b1;
      og_nxt  = rrts_pkg::idx_to_slot(gave_r ? given_r : cur_r);
      oc_nxt  = rrts_pkg::idx_to_slot(cur_r);
      os_nxt  = rrts_pkg::SLICE_W'(prio_rd) * rrts_pkg::SLICE_W'(unit_r);
      osw_nxt = sw_r;
      ost_nxt = status_r;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  // Control and scheduler registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(1);
      pos_r   <= '0;
      unit_r  <= rrts_pkg::RESET_SLICE_UNIT;
      defp_r  <= rrts_pkg::RESET_PRIORITY;
      ov_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      unit_r  <= unit_nxt;
      defp_r  <= defp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    tid_r    <= tid_nxt;
    preq_r   <= preq_nxt;
    j_r      <= j_nxt;
    found_r  <= found_nxt;
    k_r      <= k_nxt;
    cur_r    <= cur_nxt;
    given_r  <= given_nxt;
    gave_r   <= gave_nxt;
    status_r <= status_nxt;
    sw_r     <= sw_nxt;
    og_r     <= og_nxt;
    oc_r     <= oc_nxt;
    os_r     <= os_nxt;
    osw_r    <= osw_nxt;
    ost_r    <= ost_nxt;
  end

  // Task tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        state_r[i] <= (i == 0) ? rrts_pkg::SLOT_RUNNING : rrts_pkg::SLOT_EMPTY;
        prio_r[i]  <= rrts_pkg::RESET_PRIORITY;
        rl_r[i]    <= '0;
      end
    end else begin
      if (st_we) begin
        state_r[st_wa] <= st_wd;
      end
      if (prio_we) begin
        prio_r[prio_wa] <= prio_wd;
      end
      if (rl_we) begin
        rl_r[rl_wa] <= rl_wd;
      end
    end
  end

  assign out_valid        = ov_r;
  assign out_given_task   = og_r;
  assign out_current_task = oc_r;
  assign out_slice_length = os_r;
  assign out_start_switch = osw_r;
  assign out_status       = ost_r;

endmodule

`default_nettype wire

FILE: hdl/round_robin_task_scheduler_core.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_func, in_task_id, in_priority_req
// out       output     out_valid/out_ready  out_given_task, out_current_task,
//                                           out_slice_length, out_start_switch,
//                                           out_status
// cfg       input      cfg_we (no wait)     cfg_index, cfg_wdata
//
// One item at a time. Run, switch and an ignored or refused sleep pass the exec,
// head and mul states; alloc scans one slot a cycle until the lowest empty slot
// or the last slot; a sleep that removes a task walks the run list one entry a
// cycle. A new item is taken while a result waits in the output register; a
// stalled result holds the next output load.
// Reset is synchronous and restores all tables at once; no clearing pass.
`default_nettype none

module round_robin_task_scheduler_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [rrts_pkg::FUNC_W-1:0]       in_func,
  input  wire logic [rrts_pkg::TID_W-1:0]        in_task_id,
  input  wire logic [rrts_pkg::PRIO_W-1:0]       in_priority_req,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [rrts_pkg::TID_W-1:0]             out_given_task,
  output logic [rrts_pkg::TID_W-1:0]             out_current_task,
  output logic [rrts_pkg::SLICE_W-1:0]           out_slice_length,
  output logic                                   out_start_switch,
  output logic [rrts_pkg::STATUS_W-1:0]          out_status,
  input  wire logic                              cfg_we,
  input  wire logic [rrts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rrts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  rrts_pkg::cmd_t cmd;
  rrts_pkg::sts_t sts;

  // Sequencer
  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, scheduler state and output register
  rrts_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_func),
    .in_task_id       (in_task_id),
    .in_priority_req  (in_priority_req),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_given_task   (out_given_task),
    .out_current_task (out_current_task),
    .out_slice_length (out_slice_length),
    .out_start_switch (out_start_switch),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

FILE: hdl/rrts_checker.sv
`default_nettype none

module rrts_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [rrts_pkg::TID_W-1:0]        out_given_task,
  input wire logic [rrts_pkg::TID_W-1:0]        out_current_task,
  input wire logic                              out_start_switch,
  input wire logic [rrts_pkg::STATUS_W-1:0]     out_status
);

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its current task
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_current_task))
    else $error("stalled result changed");

  // One item at a time: no transfer in the cycle after a transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // A refused or failed operation never starts a switch
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_switch |-> out_status == rrts_pkg::STATUS_OK)
    else $error("switch reported with error status");

  // A failed alloc reports the current task
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rrts_pkg::STATUS_NO_SLOT
      |-> out_given_task == out_current_task)
    else $error("failed alloc gave a slot");

endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_given_task   (out_given_task),
  .out_current_task (out_current_task),
  .out_start_switch (out_start_switch),
  .out_status       (out_status)
);

`default_nettype wire
